@@ rtl/core/ibfa_pkg.sv @@
`default_nettype none

package ibfa_pkg;

	// Widths of the external fields. These are fixed by the interface.
	localparam int unsigned SIZE_W     = 32;
	localparam int unsigned STEP_IN_W  = 16;
	localparam int unsigned SLOT_OUT_W = 6;
	localparam int unsigned SUM_W      = 38;

	// Command codes carried in the command field of an input beat.
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_PLACE = 1'b1;

	typedef struct packed {
		logic                 command;
		logic [SIZE_W-1:0]    size_bytes;
		logic [STEP_IN_W-1:0] first_step;
		logic [STEP_IN_W-1:0] last_step;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic                  opened_new;
		logic                  table_full;
		logic [SUM_W-1:0]      requested_total;
		logic [SUM_W-1:0]      allocated_total;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/ibfa_table.sv @@
`default_nettype none

module ibfa_table #(
	parameter int unsigned SLOTS     = 64,
	parameter int unsigned STEP_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(SLOTS)-1:0]       waddr,
	input  wire logic [ibfa_pkg::SIZE_W-1:0]    wsize,
	input  wire logic [STEP_BITS-1:0]           wstep,
	input  wire logic                           re,
	input  wire logic [$clog2(SLOTS)-1:0]       raddr,
	output logic      [ibfa_pkg::SIZE_W-1:0]    rsize,
	output logic      [STEP_BITS-1:0]           rstep
);
	import ibfa_pkg::*;

	localparam int unsigned ENTRY_W = SIZE_W + STEP_BITS;

	// Each entry holds the slot size in the upper bits and the last step that
	// used the slot in the lower bits.
	logic [ENTRY_W-1:0] mem [SLOTS];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wsize, wstep};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rsize = rdata_q[ENTRY_W-1:STEP_BITS];
	assign rstep = rdata_q[STEP_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/ibfa_scan.sv @@
`default_nettype none

module ibfa_scan #(
	parameter int unsigned SLOTS     = 64,
	parameter int unsigned STEP_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        cmp_vld,
	input  wire logic [$clog2(SLOTS)-1:0]    cmp_idx,
	input  wire logic [ibfa_pkg::SIZE_W-1:0] cmp_size,
	input  wire logic [STEP_BITS-1:0]        cmp_step,
	input  wire logic [ibfa_pkg::SIZE_W-1:0] req_size,
	input  wire logic [STEP_BITS-1:0]        req_first,
	output logic                             found,
	output logic      [$clog2(SLOTS)-1:0]    best_idx,
	output logic      [ibfa_pkg::SIZE_W-1:0] best_size
);
	import ibfa_pkg::*;

	logic                     found_q;
	logic [$clog2(SLOTS)-1:0] best_idx_q;
	logic [SIZE_W-1:0]        best_size_q;
	logic                     fits;

	// A slot fits when it was last used strictly before the new interval
	// starts and is large enough. A strictly smaller fit replaces the current
	// best, so among equal sizes the lowest slot wins.
	assign fits = (cmp_step < req_first) && (cmp_size >= req_size) &&
		(!found_q || (cmp_size < best_size_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (cmp_vld && fits) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!start && cmp_vld && fits) begin
			best_idx_q  <= cmp_idx;
			best_size_q <= cmp_size;
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_size = best_size_q;

endmodule

`default_nettype wire

@@ rtl/core/interval_best_fit_buffer_allocator.sv @@
`default_nettype none

// Best-fit allocator that maps buffer lifetime intervals onto reusable slots.
// Input channel (in_valid / in_stall / in_data): one beat is either a clear
// command, which empties the slot table and both running totals, or an
// interval to place. Intervals are expected in ascending order of first step.
// A place beat with a zero size is dropped, as is a clear; neither gives a
// result. Every other place beat gives exactly one result beat on the output
// channel (out_valid / out_stall / out_data) with the chosen slot, whether a
// slot was opened, the table-full flag and the saturating byte totals.
// The block handles one interval at a time. With reuse enabled, the scan reads
// one table entry per cycle through the single read port of the slot memory
// and feeds it to one shared compare unit until every open slot has been read.
// With reuse disabled the scan is skipped and the beat goes to the final step.
// in_stall is high from acceptance until the result is written into the
// output register; that register lets the next beat be taken while a result
// still waits. If the receiver stalls, a finished result waits there and the
// next interval holds in its final step until the output register drains.
// Reset empties the table, clears the totals and sets reuse_enable to 1.
// The reuse_enable register is written through cfg_we / cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
module interval_best_fit_buffer_allocator #(
	parameter int unsigned SLOTS     = 64,
	parameter int unsigned STEP_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ibfa_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ibfa_pkg::out_item_t      out_data
);
	import ibfa_pkg::*;

	localparam int unsigned SLOT_W = $clog2(SLOTS);
	localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// One-hot sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;

	logic               reuse_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   req_sum_q;
	logic [SUM_W-1:0]   alloc_sum_q;
	logic [SIZE_W-1:0]  size_q;
	logic [STEP_BITS-1:0] first_q;
	logic [STEP_BITS-1:0] last_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               rd_vld_s1;
	logic [SLOT_W-1:0]  rd_idx_s1;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [STEP_BITS-1:0] first_in;
	logic [STEP_BITS-1:0] last_in;
	logic                 in_acc;
	logic                 place;
	logic                 issue;
	logic                 commit;
	logic                 table_full;
	logic                 tbl_we;
	logic [SLOT_W-1:0]    tbl_waddr;
	logic [SIZE_W-1:0]    tbl_wsize;
	logic [SIZE_W-1:0]    tbl_rsize;
	logic [STEP_BITS-1:0] tbl_rstep;
	logic                 found;
	logic [SLOT_W-1:0]    best_idx;
	logic [SIZE_W-1:0]    best_size;
	logic [SLOT_W-1:0]    chosen;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [SUM_W-1:0]     req_sum_nx;
	logic [SUM_W-1:0]     alloc_sum_nx;

	// Adds a byte count to a running total and sticks at the top value.
	function automatic logic [SUM_W-1:0] sat_add(
		input logic [SUM_W-1:0]  acc,
		input logic [SIZE_W-1:0] inc
	);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W + 1)'(inc);
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	// Steps are kept at STEP_BITS; narrower settings drop the upper bits.
	generate
		if (STEP_BITS <= STEP_IN_W) begin : g_step_trunc
			assign first_in = in_data.first_step[STEP_BITS-1:0];
			assign last_in  = in_data.last_step[STEP_BITS-1:0];
		end else begin : g_step_ext
			assign first_in = {{(STEP_BITS - STEP_IN_W){1'b0}}, in_data.first_step};
			assign last_in  = {{(STEP_BITS - STEP_IN_W){1'b0}}, in_data.last_step};
		end
	endgenerate

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign place    = in_acc && (in_data.command == CMD_PLACE) &&
		(in_data.size_bytes != '0);

	// The scan issues one read per cycle until every open slot has been read.
	assign issue = (state_q == ST_SCAN) && (scan_idx_q < cnt_q);

	// The final step waits only while an earlier result is still held.
	assign commit     = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	assign table_full = !found && (cnt_q == SLOTS_C);

	assign chosen    = found ? best_idx : cnt_q[SLOT_W-1:0];
	assign tbl_we    = commit && !table_full;
	assign tbl_waddr = chosen;
	assign tbl_wsize = found ? best_size : size_q;

	assign req_sum_nx   = sat_add(req_sum_q, size_q);
	assign alloc_sum_nx = sat_add(alloc_sum_q, size_q);

	generate
		if (SLOT_W >= SLOT_OUT_W) begin : g_slot_trunc
			assign slot_out = chosen[SLOT_OUT_W-1:0];
		end else begin : g_slot_ext
			assign slot_out = {{(SLOT_OUT_W - SLOT_W){1'b0}}, chosen};
		end
	endgenerate

	ibfa_table #(
		.SLOTS     (SLOTS),
		.STEP_BITS (STEP_BITS)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wsize (tbl_wsize),
		.wstep (last_q),
		.re    (issue),
		.raddr (scan_idx_q[SLOT_W-1:0]),
		.rsize (tbl_rsize),
		.rstep (tbl_rstep)
	);

	ibfa_scan #(
		.SLOTS     (SLOTS),
		.STEP_BITS (STEP_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (place),
		.cmp_vld   (rd_vld_s1),
		.cmp_idx   (rd_idx_s1),
		.cmp_size  (tbl_rsize),
		.cmp_step  (tbl_rstep),
		.req_size  (size_q),
		.req_first (first_q),
		.found     (found),
		.best_idx  (best_idx),
		.best_size (best_size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_q <= 1'b1;
		end else if (cfg_we) begin
			reuse_q <= cfg_wdata;
		end
	end

	// Sequencer. When the last read has been issued, its compare happens in the
	// following cycle, which is also the last cycle of the scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (place) begin
						scan_idx_q <= '0;
						state_q    <= reuse_q ? ST_SCAN : ST_COMMIT;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= scan_idx_q[SLOT_W-1:0];
		end
		if (place) begin
			size_q  <= in_data.size_bytes;
			first_q <= first_in;
			last_q  <= last_in;
		end
	end

	// Slot count and running totals. A clear resets them but leaves the entries;
	// entries at or above the count are never read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			req_sum_q   <= '0;
			alloc_sum_q <= '0;
		end else if (in_acc && (in_data.command == CMD_CLEAR)) begin
			cnt_q       <= '0;
			req_sum_q   <= '0;
			alloc_sum_q <= '0;
		end else if (commit && !table_full) begin
			req_sum_q <= req_sum_nx;
			if (!found) begin
				cnt_q       <= cnt_q + 1'b1;
				alloc_sum_q <= alloc_sum_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.slot            <= table_full ? '0 : slot_out;
			out_q.opened_new      <= !found && !table_full;
			out_q.table_full      <= table_full;
			out_q.requested_total <= table_full ? req_sum_q : req_sum_nx;
			out_q.allocated_total <= (found || table_full) ? alloc_sum_q : alloc_sum_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOTS_C)
		else $error("slot count above table depth");

	a_out_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result appeared outside the final step");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.opened_new && out_q.table_full))
		else $error("opened_new and table_full both set");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (CNT_W'(tbl_waddr) <= cnt_q) && (cnt_q != '0 || !found))
		else $error("table write beyond the open slots");

	a_no_read_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !rd_vld_s1)
		else $error("table read issued outside a scan");
`endif

endmodule

`default_nettype wire
